// ===== rtl/mci_pkg.sv =====
// Shared types and constants for the motor command interface.
package mci_pkg;

  // Command codes of an input item
  typedef enum logic [3:0] {
    CMD_TICK      = 4'd0,
    CMD_ON        = 4'd1,
    CMD_OFF       = 4'd2,
    CMD_FWD       = 4'd3,
    CMD_REV       = 4'd4,
    CMD_ECO       = 4'd5,
    CMD_POWER     = 4'd6,
    CMD_ACCEL     = 4'd7,
    CMD_REGEN     = 4'd8,
    CMD_ZERO      = 4'd9,
    CMD_GEAR_UP   = 4'd10,
    CMD_GEAR_DOWN = 4'd11
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ACCEL_MAX  = 3'd0,
    REG_REGEN_MAX  = 3'd1,
    REG_TURN_ON    = 3'd2,
    REG_GEAR_PULSE = 3'd3,
    REG_GEAR_GAP   = 3'd4
  } reg_idx_e;

  // Gear pulse sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PULSE = 3'b010,
    PH_GAP   = 3'b100
  } gear_phase_e;

  // Configuration widths and reset values
  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam logic [15:0] DefAccelMax = 16'd255;
  localparam logic [15:0] DefRegenMax = 16'd255;
  localparam logic [15:0] DefTurnOn = 16'd5000;
  localparam logic [15:0] DefGearPulse = 16'd200;
  localparam logic [15:0] DefGearGap = 16'd1200;
  localparam logic [7:0] WiperMax = 8'd255;

  // Gear queue entry values
  localparam logic GearDirUp = 1'b0;
  localparam logic GearDirDown = 1'b1;

  // Input item
  typedef struct packed {
    logic [3:0]  command;
    logic [15:0] drive_value;
    logic [15:0] regen_amount;
  } mci_in_t;

  // Result item
  typedef struct packed {
    logic       accepted;
    logic       motor_on;
    logic       main_enable;
    logic       forward;
    logic       power_mode;
    logic       gear_up_pulse;
    logic       gear_down_pulse;
    logic       drive_write;
    logic [7:0] drive_wiper;
    logic       strength_write;
    logic [7:0] strength_wiper;
    logic [5:0] gear_pending;
  } mci_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic div_sel_str;
    logic store_drv;
    logic store_str;
    logic mem_rd;
    logic pop;
  } mci_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic scale_req;
    logic is_regen;
    logic div_done;
  } mci_sts_t;

endpackage

// ===== rtl/mci_div.sv =====
// Iterative wiper divider: (value*255)/bound saturated to 8 bits, one bit per cycle.
module mci_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [7:0]  quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] dsr_q, dsr_d;
  logic [16:0] trial;
  logic [16:0] diff;

  // One restoring step on the partial remainder
  assign trial = {rem_q, low_q[7]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      dsr_d = divisor_i;
      cnt_d = 3'd0;
      if (dividend_i >= {divisor_i, 8'd0}) begin
        // quotient would not fit in 8 bits: saturate
        low_d  = mci_pkg::WiperMax;
        done_d = 1'b1;
      end else begin
        rem_d  = dividend_i[23:8];
        low_d  = dividend_i[7:0];
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!diff[16]) begin
        rem_d = diff[15:0];
        low_d = {low_q[6:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        low_d = {low_q[6:0], 1'b0};
      end
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quo_o  = low_q;

endmodule

// ===== rtl/mci_dp.sv =====
// Datapath: config registers, motor state, gear queue and pulse timing.
module mci_dp #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mci_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [mci_pkg::CfgWidth-1:0]        cfg_data_i,
  input  mci_pkg::mci_in_t                    item_i,
  input  mci_pkg::mci_ctl_t                   ctl_i,
  output mci_pkg::mci_sts_t                   sts_o,
  output mci_pkg::mci_out_t                   result_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers
  logic [15:0] accel_max_q, regen_max_q, turn_on_q, pulse_q, gap_q;

  // Captured item
  mci_pkg::mci_in_t item_q;
  mci_pkg::cmd_e    cmd;

  // Motor and gear state
  logic        on_q, on_d;
  logic        en_q, en_d;
  logic [15:0] st_q, st_d;
  logic        dir_q, dir_d;
  logic        mode_q, mode_d;
  logic [7:0]  dl_q, dl_d;
  logic [7:0]  sl_q, sl_d;
  logic        acc_q, acc_d;
  logic        dw_q, dw_d;
  logic        sw_q, sw_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] head_q, head_d;
  mci_pkg::gear_phase_e phase_q, phase_d;
  logic [15:0] gtimer_q, gtimer_d;
  logic        gdir_q, gdir_d;

  // Gear queue storage
  logic          mem_q [QUEUE_DEPTH];
  logic          rd_q;
  logic          mem_we;
  logic          mem_wdata;
  logic [AW:0]   wr_sum;
  logic [AW-1:0] wr_addr;
  logic          full;

  // Divider
  logic [15:0] div_val;
  logic [15:0] div_bound;
  logic [23:0] div_prod;
  logic [7:0]  quo;
  logic        div_done;
  logic [15:0] gtimer_dec;

  assign cmd = mci_pkg::cmd_e'(item_q.command);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_max_q <= mci_pkg::DefAccelMax;
      regen_max_q <= mci_pkg::DefRegenMax;
      turn_on_q   <= mci_pkg::DefTurnOn;
      pulse_q     <= mci_pkg::DefGearPulse;
      gap_q       <= mci_pkg::DefGearGap;
    end else if (cfg_we_i) begin
      case (mci_pkg::reg_idx_e'(cfg_idx_i))
        mci_pkg::REG_ACCEL_MAX:  accel_max_q <= cfg_data_i;
        mci_pkg::REG_REGEN_MAX:  regen_max_q <= cfg_data_i;
        mci_pkg::REG_TURN_ON:    turn_on_q   <= cfg_data_i;
        mci_pkg::REG_GEAR_PULSE: pulse_q     <= cfg_data_i;
        mci_pkg::REG_GEAR_GAP:   gap_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      item_q <= item_i;
    end
  end

  // Divider operands: value*255 = (value << 8) - value, zero bound treated as one
  assign div_val   = ctl_i.div_sel_str ? item_q.regen_amount : item_q.drive_value;
  assign div_bound = ctl_i.div_sel_str ? regen_max_q : accel_max_q;
  assign div_prod  = {div_val, 8'd0} - {8'd0, div_val};

  mci_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (div_prod),
    .divisor_i  ((div_bound == 16'd0) ? 16'd1 : div_bound),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  // Queue write address wraps for any depth
  assign full    = (cnt_q == CW'(QUEUE_DEPTH));
  assign wr_sum  = (AW+1)'(head_q) + (AW+1)'(cnt_q);
  assign wr_addr = (wr_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                   AW'(wr_sum - (AW+1)'(QUEUE_DEPTH)) : wr_sum[AW-1:0];

  assign gtimer_dec = (gtimer_q != 16'd0) ? (gtimer_q - 16'd1) : 16'd0;

  // Next-state logic for command execution, divider results and gear start
  always_comb begin
    on_d     = on_q;
    en_d     = en_q;
    st_d     = st_q;
    dir_d    = dir_q;
    mode_d   = mode_q;
    dl_d     = dl_q;
    sl_d     = sl_q;
    acc_d    = acc_q;
    dw_d     = dw_q;
    sw_d     = sw_q;
    cnt_d    = cnt_q;
    head_d   = head_q;
    phase_d  = phase_q;
    gtimer_d = gtimer_q;
    gdir_d   = gdir_q;
    mem_we   = 1'b0;
    mem_wdata = mci_pkg::GearDirUp;

    if (ctl_i.capture) begin
      acc_d = 1'b0;
      dw_d  = 1'b0;
      sw_d  = 1'b0;
    end

    if (ctl_i.exec) begin
      case (cmd)
        mci_pkg::CMD_TICK: begin
          acc_d = 1'b1;
          if (st_q != 16'd0) begin
            st_d = st_q - 16'd1;
            if (st_q == 16'd1 && en_q) begin
              on_d = 1'b1;
            end
          end
          // gear pulse and gap timing
          if (phase_q == mci_pkg::PH_PULSE || phase_q == mci_pkg::PH_GAP) begin
            gtimer_d = gtimer_dec;
            if (gtimer_dec == 16'd0) begin
              if (phase_q == mci_pkg::PH_PULSE && gap_q != 16'd0) begin
                phase_d  = mci_pkg::PH_GAP;
                gtimer_d = gap_q;
              end else begin
                phase_d = mci_pkg::PH_IDLE;
              end
            end
          end else begin
            phase_d = mci_pkg::PH_IDLE;
          end
        end
        mci_pkg::CMD_ON: begin
          if (!on_q && st_q == 16'd0) begin
            en_d  = 1'b1;
            st_d  = (turn_on_q == 16'd0) ? 16'd1 : turn_on_q;
            acc_d = 1'b1;
          end
        end
        mci_pkg::CMD_OFF: begin
          if (on_q) begin
            dl_d = 8'd0;
            sl_d = 8'd0;
            dw_d = 1'b1;
            sw_d = 1'b1;
          end
          en_d  = 1'b0;
          on_d  = 1'b0;
          acc_d = 1'b1;
        end
        mci_pkg::CMD_FWD, mci_pkg::CMD_REV: begin
          if (on_q) begin
            dir_d = (cmd == mci_pkg::CMD_FWD);
            acc_d = 1'b1;
          end
        end
        mci_pkg::CMD_ECO, mci_pkg::CMD_POWER: begin
          if (on_q && mode_q != (cmd == mci_pkg::CMD_POWER)) begin
            mode_d = (cmd == mci_pkg::CMD_POWER);
            acc_d  = 1'b1;
          end
        end
        mci_pkg::CMD_ACCEL, mci_pkg::CMD_REGEN, mci_pkg::CMD_ZERO: begin
          // scaled levels arrive later from the divider
          if (on_q) begin
            if (cmd == mci_pkg::CMD_ZERO) begin
              dl_d = 8'd0;
            end
            if (cmd != mci_pkg::CMD_REGEN) begin
              sl_d = 8'd0;
            end
            dw_d  = 1'b1;
            sw_d  = 1'b1;
            acc_d = 1'b1;
          end
        end
        mci_pkg::CMD_GEAR_UP, mci_pkg::CMD_GEAR_DOWN: begin
          if (!full) begin
            mem_we    = 1'b1;
            mem_wdata = (cmd == mci_pkg::CMD_GEAR_DOWN) ? mci_pkg::GearDirDown
                                                        : mci_pkg::GearDirUp;
            cnt_d     = cnt_q + CW'(1);
            acc_d     = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (ctl_i.store_drv) begin
      dl_d = quo;
    end
    if (ctl_i.store_str) begin
      sl_d = quo;
    end

    // Idle sequencer pops the queue head and starts a pulse
    if (ctl_i.pop && phase_q == mci_pkg::PH_IDLE && cnt_q != CW'(0)) begin
      gdir_d   = rd_q;
      head_d   = (head_q == AW'(QUEUE_DEPTH - 1)) ? AW'(0) : head_q + AW'(1);
      cnt_d    = cnt_q - CW'(1);
      phase_d  = mci_pkg::PH_PULSE;
      gtimer_d = (pulse_q == 16'd0) ? 16'd1 : pulse_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q     <= 1'b0;
      en_q     <= 1'b0;
      st_q     <= 16'd0;
      dir_q    <= 1'b1;
      mode_q   <= 1'b0;
      dl_q     <= 8'd0;
      sl_q     <= 8'd0;
      acc_q    <= 1'b0;
      dw_q     <= 1'b0;
      sw_q     <= 1'b0;
      cnt_q    <= '0;
      head_q   <= '0;
      phase_q  <= mci_pkg::PH_IDLE;
      gtimer_q <= 16'd0;
      gdir_q   <= 1'b0;
    end else begin
      on_q     <= on_d;
      en_q     <= en_d;
      st_q     <= st_d;
      dir_q    <= dir_d;
      mode_q   <= mode_d;
      dl_q     <= dl_d;
      sl_q     <= sl_d;
      acc_q    <= acc_d;
      dw_q     <= dw_d;
      sw_q     <= sw_d;
      cnt_q    <= cnt_d;
      head_q   <= head_d;
      phase_q  <= phase_d;
      gtimer_q <= gtimer_d;
      gdir_q   <= gdir_d;
    end
  end

  // Queue memory: one write port, registered read at the head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= mem_wdata;
    end
    if (ctl_i.mem_rd) begin
      rd_q <= mem_q[head_q];
    end
  end

  // Status to controller
  assign sts_o.scale_req = on_q && (cmd == mci_pkg::CMD_ACCEL || cmd == mci_pkg::CMD_REGEN);
  assign sts_o.is_regen  = (cmd == mci_pkg::CMD_REGEN);
  assign sts_o.div_done  = div_done;

  // Result item straight from state registers
  assign result_o.accepted        = acc_q;
  assign result_o.motor_on        = on_q;
  assign result_o.main_enable     = en_q;
  assign result_o.forward         = dir_q;
  assign result_o.power_mode      = mode_q;
  assign result_o.gear_up_pulse   = (phase_q == mci_pkg::PH_PULSE) && !gdir_q;
  assign result_o.gear_down_pulse = (phase_q == mci_pkg::PH_PULSE) && gdir_q;
  assign result_o.drive_write     = dw_q;
  assign result_o.drive_wiper     = dl_q;
  assign result_o.strength_write  = sw_q;
  assign result_o.strength_wiper  = sl_q;
  assign result_o.gear_pending    = 6'(cnt_q);

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("gear queue count above depth");

  a_gear_timer_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != mci_pkg::PH_IDLE |-> gtimer_q != 16'd0)
    else $error("gear phase active with expired timer");

  a_on_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    on_q |-> en_q)
    else $error("motor on without main enable");
`endif

endmodule

// ===== rtl/mci_ctrl.sv =====
// Controller: sequences capture, execute, scaling, queue pop and result strobe.
module mci_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mci_pkg::mci_sts_t  sts_i,
  output mci_pkg::mci_ctl_t  ctl_o,
  output logic               busy_o,
  output logic               done_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_EXEC    = 7'b0000010,
    S_DIV_DRV = 7'b0000100,
    S_DIV_STR = 7'b0001000,
    S_RD      = 7'b0010000,
    S_POP     = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.exec = 1'b1;
        if (sts_i.scale_req) begin
          ctl_o.div_start = 1'b1;
          state_d         = S_DIV_DRV;
        end else begin
          state_d = S_RD;
        end
      end
      S_DIV_DRV: begin
        if (sts_i.div_done) begin
          ctl_o.store_drv = 1'b1;
          if (sts_i.is_regen) begin
            ctl_o.div_start   = 1'b1;
            ctl_o.div_sel_str = 1'b1;
            state_d           = S_DIV_STR;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_DIV_STR: begin
        if (sts_i.div_done) begin
          ctl_o.store_str = 1'b1;
          state_d         = S_RD;
        end
      end
      S_RD: begin
        ctl_o.mem_rd = 1'b1;
        state_d      = S_POP;
      end
      S_POP: begin
        ctl_o.pop = 1'b1;
        state_d   = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

`ifndef SYNTH
  a_start_execs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> (state_q == S_EXEC))
    else $error("accepted item did not enter execute");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV_DRV || state_q == S_DIV_STR))
    else $error("divider finished while no division was pending");
`endif

endmodule

// ===== rtl/motor_command_interface.sv =====
// Motor command interface top level: command port, config port, result strobe.
//
// Usage: drive item_i and raise start while busy is low; the item is taken at
// that clock edge and busy is high from then on. Exactly one result item per
// command appears on result_o for a single cycle with result_valid_o high.
// The receiver cannot hold results off; it must sample result_o in that cycle.
// The path runs through execute, queue read, queue pop and strobe for most
// commands; accelerate adds one pass of the shared 8-step divider that scales
// wiper values and regenerate adds two, a pass being cut short when the value
// saturates. Items are taken one at a time: busy falls the cycle after the
// strobe, so a new item is not taken while one is in flight. Configuration
// registers are written through cfg_we_i, cfg_idx_i and cfg_data_i with no
// wait; the user must write them only while the block is idle, which the block
// itself does not enforce.
// Reset (rst_ni low, asynchronous) returns all configuration registers to their defaults,
// turns the motor off, empties the gear queue and drops busy; no clearing
// pass is needed.
module motor_command_interface #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  mci_pkg::mci_in_t                item_i,
  output mci_pkg::mci_out_t               result_o,
  output logic                            result_valid_o,
  input  logic                            cfg_we_i,
  input  logic [mci_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [mci_pkg::CfgWidth-1:0]    cfg_data_i
);

  mci_pkg::mci_ctl_t ctl;
  mci_pkg::mci_sts_t sts;

  // Sequencing
  mci_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy),
    .done_o  (result_valid_o)
  );

  // State and arithmetic
  mci_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .result_o   (result_o)
  );

endmodule

// ===== tb/motor_command_interface_tb.sv =====
// Self-checking testbench for the motor command interface: commands, settings, gear queue.
`timescale 1ns / 100ps

import mci_pkg::*;

// Tracks controller state, predicts each response and compares it with the block.
class command_checker;
  localparam int unsigned QueueDepth = 32;

  // register copies
  logic [15:0] accel_max;
  logic [15:0] regen_max;
  logic [15:0] turn_on_ticks;
  logic [15:0] pulse_ticks;
  logic [15:0] gap_ticks;

  // controller state
  logic        on_flag;
  logic        enable_flag;
  logic [15:0] start_timer;
  logic        forward_dir;
  logic        power_sel;
  logic [7:0]  drive_level;
  logic [7:0]  strength_level;
  logic        gear_fifo [QueueDepth];
  int unsigned fifo_count;
  int unsigned fifo_head;
  gear_phase_e gear_phase;
  logic [15:0] gear_timer;
  logic        gear_dir;

  mci_out_t    awaited [$];
  int unsigned errors;
  int unsigned n_checked;
  int unsigned n_motor_on;
  int unsigned n_wiper_writes;
  int unsigned n_pulses;
  int unsigned n_queue_full;

  function new();
    accel_max      = DefAccelMax;
    regen_max      = DefRegenMax;
    turn_on_ticks  = DefTurnOn;
    pulse_ticks    = DefGearPulse;
    gap_ticks      = DefGearGap;
    on_flag        = 1'b0;
    enable_flag    = 1'b0;
    start_timer    = '0;
    forward_dir    = 1'b1;
    power_sel      = 1'b0;
    drive_level    = '0;
    strength_level = '0;
    foreach (gear_fifo[i]) gear_fifo[i] = GearDirUp;
    fifo_count     = 0;
    fifo_head      = 0;
    gear_phase     = PH_IDLE;
    gear_timer     = '0;
    gear_dir       = GearDirUp;
    errors         = 0;
    n_checked      = 0;
    n_motor_on     = 0;
    n_wiper_writes = 0;
    n_pulses       = 0;
    n_queue_full   = 0;
  endfunction

  function void set_reg(reg_idx_e idx, logic [15:0] val);
    case (idx)
      REG_ACCEL_MAX:  accel_max = val;
      REG_REGEN_MAX:  regen_max = val;
      REG_TURN_ON:    turn_on_ticks = val;
      REG_GEAR_PULSE: pulse_ticks = val;
      REG_GEAR_GAP:   gap_ticks = val;
      default: ;
    endcase
  endfunction

  // value*255/bound, bound of zero acts as one, saturated to the wiper range
  function logic [7:0] wiper_for(logic [15:0] value, logic [15:0] bound);
    int unsigned b;
    int unsigned w;
    b = (bound == 0) ? 1 : int'(bound);
    w = int'(value) * 255 / b;
    return (w > 255) ? WiperMax : w[7:0];
  endfunction

  function logic [15:0] nonzero(logic [15:0] v);
    return (v == 0) ? 16'd1 : v;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  // Accepted item: advance the state and queue the response it must produce
  function void note_command(mci_in_t it);
    mci_out_t r;
    logic     acc;
    logic     dw;
    logic     sw;
    acc = 1'b0;
    dw  = 1'b0;
    sw  = 1'b0;
    case (it.command)
      CMD_TICK: begin
        acc = 1'b1;
        if (start_timer != 0) begin
          start_timer = start_timer - 1'b1;
          if (start_timer == 0 && enable_flag) on_flag = 1'b1;
        end
        // gear sequencer timing
        if (gear_phase != PH_IDLE) begin
          if (gear_timer != 0) gear_timer = gear_timer - 1'b1;
          if (gear_timer == 0) begin
            if (gear_phase == PH_PULSE && gap_ticks != 0) begin
              gear_phase = PH_GAP;
              gear_timer = gap_ticks;
            end else begin
              gear_phase = PH_IDLE;
            end
          end
        end
      end
      CMD_ON: begin
        if (!on_flag && start_timer == 0) begin
          enable_flag = 1'b1;
          start_timer = nonzero(turn_on_ticks);
          acc = 1'b1;
        end
      end
      CMD_OFF: begin
        if (on_flag) begin
          drive_level    = '0;
          strength_level = '0;
          dw = 1'b1;
          sw = 1'b1;
        end
        enable_flag = 1'b0;
        on_flag     = 1'b0;
        acc = 1'b1;
      end
      CMD_FWD, CMD_REV: begin
        if (on_flag) begin
          forward_dir = (it.command == CMD_FWD);
          acc = 1'b1;
        end
      end
      CMD_ECO, CMD_POWER: begin
        if (on_flag && power_sel != (it.command == CMD_POWER)) begin
          power_sel = (it.command == CMD_POWER);
          acc = 1'b1;
        end
      end
      CMD_ACCEL, CMD_REGEN, CMD_ZERO: begin
        if (on_flag) begin
          drive_level = (it.command == CMD_ZERO) ? 8'd0 :
                        wiper_for(it.drive_value, accel_max);
          strength_level = (it.command == CMD_REGEN) ?
                           wiper_for(it.regen_amount, regen_max) : 8'd0;
          dw  = 1'b1;
          sw  = 1'b1;
          acc = 1'b1;
        end
      end
      CMD_GEAR_UP, CMD_GEAR_DOWN: begin
        if (fifo_count >= QueueDepth) begin
          n_queue_full++;
        end else begin
          gear_fifo[(fifo_head + fifo_count) % QueueDepth] =
            (it.command == CMD_GEAR_DOWN) ? GearDirDown : GearDirUp;
          fifo_count++;
          acc = 1'b1;
        end
      end
      default: ;
    endcase

    // idle sequencer pops the queue head, possibly in the same step as the push
    if (gear_phase == PH_IDLE && fifo_count > 0) begin
      gear_dir   = gear_fifo[fifo_head];
      fifo_head  = (fifo_head + 1) % QueueDepth;
      fifo_count--;
      gear_phase = PH_PULSE;
      gear_timer = nonzero(pulse_ticks);
    end

    r.accepted        = acc;
    r.motor_on        = on_flag;
    r.main_enable     = enable_flag;
    r.forward         = forward_dir;
    r.power_mode      = power_sel;
    r.gear_up_pulse   = (gear_phase == PH_PULSE && gear_dir == GearDirUp);
    r.gear_down_pulse = (gear_phase == PH_PULSE && gear_dir == GearDirDown);
    r.drive_write     = dw;
    r.drive_wiper     = drive_level;
    r.strength_write  = sw;
    r.strength_wiper  = strength_level;
    r.gear_pending    = fifo_count[5:0];
    awaited.push_back(r);
  endfunction

  // Compare one strobed response with the oldest prediction
  function void check_result(mci_out_t got);
    mci_out_t exp_r;
    string    diff;
    n_checked++;
    if (awaited.size() == 0) begin
      errors++;
      if (errors <= 10) $display("response %0d with none awaited: got %p", n_checked, got);
      return;
    end
    exp_r = awaited.pop_front();
    diff = "";
    if (got.accepted !== exp_r.accepted) diff = {diff, " accepted"};
    if (got.motor_on !== exp_r.motor_on) diff = {diff, " motor_on"};
    if (got.main_enable !== exp_r.main_enable) diff = {diff, " main_enable"};
    if (got.forward !== exp_r.forward) diff = {diff, " forward"};
    if (got.power_mode !== exp_r.power_mode) diff = {diff, " power_mode"};
    if (got.gear_up_pulse !== exp_r.gear_up_pulse) diff = {diff, " gear_up_pulse"};
    if (got.gear_down_pulse !== exp_r.gear_down_pulse) diff = {diff, " gear_down_pulse"};
    if (got.drive_write !== exp_r.drive_write) diff = {diff, " drive_write"};
    if (got.drive_wiper !== exp_r.drive_wiper) diff = {diff, " drive_wiper"};
    if (got.strength_write !== exp_r.strength_write) diff = {diff, " strength_write"};
    if (got.strength_wiper !== exp_r.strength_wiper) diff = {diff, " strength_wiper"};
    if (got.gear_pending !== exp_r.gear_pending) diff = {diff, " gear_pending"};
    if (diff != "") begin
      errors++;
      if (errors <= 10)
        $display("response %0d differs in%s: expected %p got %p", n_checked, diff, exp_r, got);
    end
    if (got.motor_on === 1'b1) n_motor_on++;
    if (got.drive_write === 1'b1) n_wiper_writes++;
    if (got.gear_up_pulse === 1'b1 || got.gear_down_pulse === 1'b1) n_pulses++;
  endfunction
endclass

module motor_command_interface_tb;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  mci_in_t           item_i;
  mci_out_t          result_o;
  logic              result_valid_o;
  logic              cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [CfgWidth-1:0]    cfg_data_i;

  command_checker sb = new();
  int unsigned    idle_pct;
  int unsigned    n_sent;
  int unsigned    n_known;
  int unsigned    n_settings;

  motor_command_interface u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // response monitor: the strobe lasts one cycle and cannot be stalled
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) sb.check_result(result_o);
  end

  // Offer one item, wait for the handshake, then maybe idle for a burst
  task automatic send_cmd(input logic [3:0] code, input logic [15:0] dv,
                          input logic [15:0] ra);
    mci_in_t it;
    it.command      = code;
    it.drive_value  = dv;
    it.regen_amount = ra;
    item_i <= it;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_command(it);
    n_sent++;
    if (code <= CMD_GEAR_DOWN) n_known++;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Registers change only once every response is in
  task automatic configure(input logic [15:0] am, input logic [15:0] rm,
                           input logic [15:0] ton, input logic [15:0] gp,
                           input logic [15:0] gg);
    logic [15:0] vals [5];
    vals = '{am, rm, ton, gp, gg};
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(reg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Amounts biased toward zero, full range and the scaling bound
  function automatic logic [15:0] pick_amount(logic [15:0] bound);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return bound;
      3: return bound - 1'b1;
      4: return bound + 1'b1;
      5: return 16'($urandom_range(0, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed sequences (power up then drive, gear bursts, tick runs)
  task automatic run_random(input int unsigned n_items);
    int unsigned goal;
    int unsigned pick;
    int unsigned k;
    goal = n_known + n_items;
    while (n_known < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_cmd(CMD_ON, 16'($urandom), 16'($urandom));
        k = (sb.turn_on_ticks == 0) ? 1 : int'(sb.turn_on_ticks);
        k = k + $urandom_range(0, 2);
        if (k > 40) k = $urandom_range(1, 40);
        repeat (k) send_cmd(CMD_TICK, 16'($urandom), 16'($urandom));
        repeat ($urandom_range(2, 8))
          send_cmd(4'($urandom_range(CMD_FWD, CMD_ZERO)), pick_amount(sb.accel_max),
                   pick_amount(sb.regen_max));
      end else if (pick < 20) begin
        // long bursts overflow the queue
        repeat ($urandom_range(1, 36))
          send_cmd($urandom_range(0, 1) ? CMD_GEAR_DOWN : CMD_GEAR_UP, 16'($urandom),
                   16'($urandom));
        repeat ($urandom_range(0, 10)) send_cmd(CMD_TICK, 16'($urandom), 16'($urandom));
      end else if (pick < 25) begin
        send_cmd(CMD_OFF, 16'($urandom), 16'($urandom));
      end else if (pick < 28) begin
        send_cmd(4'(CMD_GEAR_DOWN) + 4'($urandom_range(1, 4)), 16'($urandom),
                 16'($urandom));
      end else if (pick < 45) begin
        repeat ($urandom_range(1, 8)) send_cmd(CMD_TICK, 16'($urandom), 16'($urandom));
      end else begin
        send_cmd(4'($urandom_range(CMD_TICK, CMD_GEAR_DOWN)), pick_amount(sb.accel_max),
                 pick_amount(sb.regen_max));
      end
    end
  endtask

  // Stimulus
  initial begin
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    item_i     <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_ACCEL_MAX;
    cfg_data_i <= '0;
    idle_pct   = 0;
    n_sent     = 0;
    n_known    = 0;
    n_settings = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: refusals while off, power up, every drive command, gears, shutdown
    configure(16'd255, 16'd255, 16'd3, 16'd2, 16'd3);
    send_cmd(CMD_OFF, 16'd0, 16'd0);
    send_cmd(CMD_FWD, 16'd0, 16'd0);
    send_cmd(CMD_ACCEL, 16'd100, 16'd0);
    send_cmd(CMD_POWER, 16'd0, 16'd0);
    send_cmd(CMD_ON, 16'd0, 16'd0);
    send_cmd(CMD_ON, 16'd0, 16'd0);
    repeat (3) send_cmd(CMD_TICK, 16'd0, 16'd0);
    send_cmd(CMD_ON, 16'd0, 16'd0);
    send_cmd(CMD_REV, 16'd0, 16'd0);
    send_cmd(CMD_FWD, 16'd0, 16'd0);
    send_cmd(CMD_ECO, 16'd0, 16'd0);
    send_cmd(CMD_POWER, 16'd0, 16'd0);
    send_cmd(CMD_ACCEL, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_ACCEL, 16'd0, 16'd0);
    send_cmd(CMD_REGEN, 16'd255, 16'hFFFF);
    send_cmd(CMD_REGEN, 16'd128, 16'd0);
    send_cmd(CMD_ZERO, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_GEAR_UP, 16'd0, 16'd0);
    send_cmd(CMD_GEAR_DOWN, 16'd0, 16'd0);
    send_cmd(4'hF, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_OFF, 16'd0, 16'd0);
    // turn-on delay expires after the enable was dropped
    send_cmd(CMD_ON, 16'd0, 16'd0);
    send_cmd(CMD_OFF, 16'd0, 16'd0);
    repeat (3) send_cmd(CMD_TICK, 16'd0, 16'd0);

    idle_pct = 30;
    run_random(210);

    // smallest bounds and durations, no gap
    configure(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
    idle_pct = 0;
    run_random(210);

    configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
              16'($urandom_range(0, 8)));
    idle_pct = 50;
    run_random(210);

    // zero bounds, turn-on delay and pulse length act as one
    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'($urandom_range(0, 4)));
    idle_pct = 20;
    run_random(210);

    configure(16'hFFFF, 16'hFFFF, 16'd2, 16'd3, 16'd1);
    idle_pct = 30;
    run_random(210);

    // longest durations last, with no idling
    configure(16'($urandom_range(1, 1000)), 16'($urandom_range(1, 1000)),
              16'hFFFF, 16'hFFFF, 16'hFFFF);
    idle_pct = 0;
    run_random(210);

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("Sent %0d commands across %0d register settings; %0d responses checked.",
             n_sent, n_settings, sb.n_checked);
    $display("Motor on in %0d responses, %0d wiper writes, %0d pulse cycles, %0d full-queue drops.",
             sb.n_motor_on, sb.n_wiper_writes, sb.n_pulses, sb.n_queue_full);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[motor_command_interface] OK");
    end else begin
      $display("%0d errors, %0d responses missing", sb.errors, sb.pending());
      $display("[motor_command_interface] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Watchdog expired with %0d responses outstanding", sb.pending());
    $display("[motor_command_interface] ERROR");
    $finish;
  end

endmodule
